>>> sv/dsrm_pkg.sv
`default_nettype none

package dsrm_pkg;

    // Fixed field and register widths
    localparam int BYTE_W    = 8;
    localparam int CHARS_W   = 64;
    localparam int STAR_W    = 16;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;

    // Token byte that matches any subject byte
    localparam logic [BYTE_W-1:0] ANY_BYTE = 8'h2E;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHARS_LOW   = 2'd0,
        REG_CHARS_HIGH  = 2'd1,
        REG_STAR_MASK   = 2'd2,
        REG_TOKEN_COUNT = 2'd3
    } cfg_reg_t;

    // Signals passed from one cell to the next one up the row
    typedef struct packed {
        logic pre_carry;   // skip into this position, current set
        logic fwd;         // non-starred token consumed the byte
        logic post_carry;  // skip into this position, next set
    } chain_link_t;

endpackage

`default_nettype wire

>>> sv/dsrm_cell.sv
`default_nettype none

module dsrm_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              load,
    input  wire logic                              restart,
    input  wire logic [dsrm_pkg::BYTE_W-1:0]       subject,
    input  wire logic [dsrm_pkg::BYTE_W-1:0]       tok_char,
    input  wire logic                              starred,
    input  wire logic [dsrm_pkg::COUNT_W-1:0]      used_count,
    input  wire dsrm_pkg::chain_link_t             link_in,
    output dsrm_pkg::chain_link_t                  link_out,
    output logic                                   next_bit,
    output logic                                   pos_bit
);

    localparam logic [dsrm_pkg::COUNT_W-1:0] MY_POS = dsrm_pkg::COUNT_W'(INDEX);
    localparam logic                         START  = (INDEX == 0);

    logic pos_reg;
    logic pos_next;
    logic tok_live;
    logic pos_live;
    logic cur;
    logic hit;
    logic nxt;

    always_comb begin
        tok_live = (MY_POS < used_count);
        pos_live = (MY_POS <= used_count);
        // current set, closed over the skip from the position below
        cur      = (pos_reg & pos_live) | link_in.pre_carry;
        hit      = cur & tok_live &
                   ((tok_char == dsrm_pkg::ANY_BYTE) || (tok_char == subject));
        // a starred token stays put on a hit, a plain one advances
        nxt      = (hit & starred) | link_in.fwd | link_in.post_carry;

        link_out.pre_carry  = cur & starred & tok_live;
        link_out.fwd        = hit & ~starred;
        link_out.post_carry = nxt & starred & tok_live;
    end

    always_comb begin
        pos_next = pos_reg;
        if (load) begin
            pos_next = restart ? START : nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= START;
        end else begin
            pos_reg <= pos_next;
        end
    end

    assign next_bit = nxt;
    assign pos_bit  = pos_reg;

endmodule

`default_nettype wire

>>> sv/dot_star_regex_matcher_unit.sv
// Whole-string matcher for patterns of literal bytes, '.' and postfix '*'.
// Software loads the compiled pattern through the write port: token bytes
// (0x2E matches any byte), a star mask and the token count (clamped to
// MAX_TOKENS). Configuration must be written between items; the block does not enforce it.
// Input channel: one subject byte per item in s_tdata, s_tlast on the last
// byte of the string. Result channel: m_tdata bit 0 says whether the bytes
// so far match the whole pattern, m_tlast copies the input tlast.
// Throughput is one item per cycle while the receiver keeps up; each result
// appears in the cycle after its item is accepted. The set of active
// positions lives in a row of cells, one per token, and the per-item cost
// is set by the skip closure rippling up that row twice (current set, then next set).
// The result sits in an output register; while it waits, a new item is still
// taken as long as m_tready is high in the same cycle. When the receiver
// stalls with a result held, s_tready drops and the state holds.
// Reset clears the configuration registers to zero, leaves only position zero active and
// empties the output register. After the item flagged last, the set returns
// to its start.
`default_nettype none

module dot_star_regex_matcher_unit #(
    parameter int MAX_TOKENS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [dsrm_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [dsrm_pkg::CFG_DAT_W-1:0]      cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] subject_byte
    input  wire logic                                s_tlast,   // is_final
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [7:0]                               m_tdata,   // [0] matched, [7:1] zero
    output logic                                     m_tlast    // string_done
);

    localparam int IDX_W = $clog2(MAX_TOKENS + 1);

    logic [dsrm_pkg::CHARS_W-1:0] chars_low_reg;
    logic [dsrm_pkg::CHARS_W-1:0] chars_high_reg;
    logic [dsrm_pkg::STAR_W-1:0]  star_reg;
    logic [dsrm_pkg::COUNT_W-1:0] count_reg;

    logic [2*dsrm_pkg::CHARS_W-1:0] chars_all;
    logic [dsrm_pkg::COUNT_W-1:0]   used_count;
    logic                           accept;

    dsrm_pkg::chain_link_t links [0:MAX_TOKENS];
    logic [MAX_TOKENS:0]   next_vec;
    logic [MAX_TOKENS:0]   state_vec;

    logic end_reg;
    logic end_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic matched_reg;
    logic matched_next;
    logic done_reg;
    logic done_next;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
            star_reg       <= '0;
            count_reg      <= '0;
        end else if (cfg_wr_en) begin
            unique case (dsrm_pkg::cfg_reg_t'(cfg_addr))
                dsrm_pkg::REG_CHARS_LOW:   chars_low_reg  <= cfg_wdata;
                dsrm_pkg::REG_CHARS_HIGH:  chars_high_reg <= cfg_wdata;
                dsrm_pkg::REG_STAR_MASK:   star_reg <= cfg_wdata[dsrm_pkg::STAR_W-1:0];
                dsrm_pkg::REG_TOKEN_COUNT: count_reg <= cfg_wdata[dsrm_pkg::COUNT_W-1:0];
            endcase
        end
    end

    assign chars_all  = {chars_high_reg, chars_low_reg};
    assign used_count = (count_reg > dsrm_pkg::COUNT_W'(MAX_TOKENS))
                      ? dsrm_pkg::COUNT_W'(MAX_TOKENS) : count_reg;

    assign s_tready = ~m_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    assign links[0] = '0;

    for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
        dsrm_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .load       (accept),
            .restart    (s_tlast),
            .subject    (s_tdata),
            .tok_char   (chars_all[8*i +: 8]),
            .starred    (star_reg[i]),
            .used_count (used_count),
            .link_in    (links[i]),
            .link_out   (links[i+1]),
            .next_bit   (next_vec[i]),
            .pos_bit    (state_vec[i])
        );
    end

    // End position: reached by the last token advancing or skipping
    assign next_vec[MAX_TOKENS]  = links[MAX_TOKENS].fwd | links[MAX_TOKENS].post_carry;
    assign state_vec[MAX_TOKENS] = end_reg;

    always_comb begin
        end_next     = end_reg;
        m_valid_next = m_valid_reg;
        matched_next = matched_reg;
        done_next    = done_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            end_next     = s_tlast ? 1'b0 : next_vec[MAX_TOKENS];
            m_valid_next = 1'b1;
            matched_next = next_vec[used_count[IDX_W-1:0]];
            done_next    = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            end_reg     <= end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        matched_reg <= matched_next;
        done_reg    <= done_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, matched_reg};
    assign m_tlast  = done_reg;

    localparam logic [MAX_TOKENS:0] START_SET = (MAX_TOKENS + 1)'(1);

    a_reset_start: assert property (@(posedge aclk)
        !aresetn |=> (state_vec == START_SET) && !m_tvalid)
        else $error("state not at start after reset");

    a_final_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> (state_vec == START_SET) && m_tlast)
        else $error("set did not return to start after last item");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted item produced no result");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("item taken while result stalled");

    a_dead_set: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_tlast && (state_vec == '0) |=> (state_vec == '0) && !m_tdata[0])
        else $error("dead set revived");

endmodule

`default_nettype wire
